// ----- design/cvfc_pkg.sv -----
// shared types, constants and the crc-8 byte update for the cell voltage frame checker
package cvfc_pkg;

  localparam int CELLS_MAX  = 10;
  localparam int CELL_W     = 4;
  localparam int BANK_W     = 2;
  localparam int CODE_W     = 12;
  localparam int OFFSET_W   = 13;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_DATA_W = 24;

  localparam logic [OFFSET_W-1:0] CODE_BIAS = 13'd512;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = 4'd15;

  // reset values of the configuration registers
  localparam logic [CODE_W-1:0]  LOW_LIMIT_RST   = 12'd1845;
  localparam logic [CODE_W-1:0]  HIGH_LIMIT_RST  = 12'd3712;
  localparam logic [COUNT_W-1:0] PERSIST_RST     = 4'd5;
  localparam logic [CELL_W-1:0]  CELLS_FIRST_RST = 4'd10;
  localparam logic [CELL_W-1:0]  CELLS_OTHER_RST = 4'd8;
  localparam logic [7:0]         PEC_SEED_RST    = 8'd65;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT   = 3'd0,
    REG_HIGH_LIMIT  = 3'd1,
    REG_PERSIST     = 3'd2,
    REG_CELLS_FIRST = 3'd3,
    REG_CELLS_OTHER = 3'd4,
    REG_PEC_SEED    = 3'd5
  } cvfc_reg_t;

  // work handed to the cell sequencer on a pec beat
  typedef struct packed {
    logic [BANK_W-1:0] bank_index;
    logic [CELL_W-1:0] ncell;
    logic              pec_ok;
    logic              link_fault;
  } cvfc_cmd_t;

  // limits the sequencer checks against
  typedef struct packed {
    logic [CODE_W-1:0]  low_limit;
    logic [CODE_W-1:0]  high_limit;
    logic [COUNT_W-1:0] persist;
  } cvfc_lim_t;

  // x^8+x^2+x+1, msb first, one bit per step
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = d[i] ^ r[7];
      r  = {r[6:2], r[1] ^ fb, r[0] ^ fb, fb};
    end
    return r;
  endfunction

endpackage

// ----- design/cvfc_ram.sv -----
// generic single-write, single-read ram with registered read data
module cvfc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/cvfc_cell_seq.sv -----
// cell sequencer: unpacks codes from the byte store, updates fault counts, drives results
module cvfc_cell_seq #(
  parameter int BANK_COUNT     = 3,
  parameter int BYTES_PER_BANK = 15,
  parameter int DATA_AW        = $clog2(BYTES_PER_BANK)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  cvfc_pkg::cvfc_cmd_t            cmd,
  input  cvfc_pkg::cvfc_lim_t            lim,
  output logic                           accept_ok,
  output logic [DATA_AW-1:0]             rd_addr,
  input  logic [7:0]                     rd_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cvfc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import cvfc_pkg::*;

  localparam int FDEPTH = BANK_COUNT * CELLS_MAX;
  localparam int FAW    = $clog2(FDEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RDA  = 5'b00010,
    S_RDB  = 5'b00100,
    S_CALC = 5'b01000,
    S_OUT  = 5'b10000
  } seq_state_t;

  seq_state_t             state_r, state_nxt;
  cvfc_cmd_t              cmd_r;
  logic [CELL_W-1:0]      cell_r;
  logic [FAW-1:0]         slot_r;
  logic [7:0]             byte_a_r;
  logic                   bounds_flag_r;
  logic [FDEPTH-1:0]      fvalid_r;
  logic [OUT_DATA_W-1:0]  out_tdata_r;
  logic                   out_tlast_r;

  logic [CELL_W-1:0]      base;
  logic [CELL_W-1:0]      idx_a;
  logic [CELL_W-1:0]      idx_b;
  logic                   zero_a;
  logic                   zero_b;
  logic [7:0]             byte_b;
  logic [CODE_W-1:0]      code;
  logic                   ok;
  logic [COUNT_W-1:0]     f_rdata;
  logic [COUNT_W-1:0]     cur_cnt;
  logic [COUNT_W-1:0]     new_cnt;
  logic                   bounds_nxt;
  logic                   last;
  logic [OFFSET_W-1:0]    offset;
  logic [5:0]             slot_base;
  logic                   f_we;

  // byte indexes of cell c: even cells start at 3*(c/2), odd ones one byte later
  assign base   = {cell_r[3:1], 1'b0} + {1'b0, cell_r[3:1]};
  assign idx_a  = cell_r[0] ? base + 4'd1 : base;
  assign idx_b  = idx_a + 4'd1;
  assign zero_a = idx_a >= CELL_W'(BYTES_PER_BANK);
  assign zero_b = idx_b >= CELL_W'(BYTES_PER_BANK);
  assign rd_addr = (state_r == S_RDB) ? idx_b[DATA_AW-1:0] : idx_a[DATA_AW-1:0];
  assign byte_b  = zero_b ? 8'd0 : rd_data;

  always_comb begin
    if (cell_r[0]) begin
      code = {byte_b, byte_a_r[7:4]};
    end else begin
      code = {byte_b[3:0], byte_a_r};
    end
  end

  assign ok      = (code > lim.low_limit) && (code < lim.high_limit);
  assign cur_cnt = fvalid_r[slot_r] ? f_rdata : '0;
  assign new_cnt = ok ? '0 : ((cur_cnt == COUNT_MAX) ? COUNT_MAX : cur_cnt + 4'd1);
  assign bounds_nxt = bounds_flag_r | (!ok && (new_cnt >= lim.persist));
  assign last    = (cell_r + 4'd1) == cmd_r.ncell;
  assign offset  = {1'b0, code} - CODE_BIAS;
  assign f_we    = (state_r == S_CALC);
  assign slot_base = 6'(cmd.bank_index) * 6'(CELLS_MAX);

  cvfc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (FDEPTH)
  ) u_fault_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (slot_r),
    .wdata (new_cnt),
    .raddr (slot_r),
    .rdata (f_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_CALC;
      S_CALC: state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) begin
          state_nxt = (out_tlast_r && !start) ? S_IDLE : S_RDA;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      bounds_flag_r <= 1'b0;
      fvalid_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (f_we) begin
        bounds_flag_r    <= bounds_nxt;
        fvalid_r[slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && accept_ok) begin
      cmd_r  <= cmd;
      cell_r <= '0;
      slot_r <= slot_base[FAW-1:0];
    end
    if (state_r == S_OUT && out_tready && !out_tlast_r) begin
      cell_r <= cell_r + 4'd1;
      slot_r <= slot_r + FAW'(1);
    end
    if (state_r == S_RDB) begin
      byte_a_r <= zero_a ? 8'd0 : rd_data;
    end
    if (state_r == S_CALC) begin
      out_tdata_r <= {1'b0, bounds_nxt, cmd_r.link_fault, cmd_r.pec_ok, ok,
                      offset, cell_r, cmd_r.bank_index};
      out_tlast_r <= last;
    end
  end

  // the next beat may land in the cycle the bank's final result is taken
  assign accept_ok  = (state_r == S_IDLE) || (state_r == S_OUT && out_tlast_r && out_tready);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ----- design/cell_voltage_frame_checker_top.sv -----
// top level of the cell voltage frame checker: config, byte framing, crc and pec check
//
// in channel: one received byte per beat, in_tuser high on the first data byte of a
//   readback. each bank is BYTES_PER_BANK data bytes then one pec byte.
// out channel: one beat per checked cell, in arrival order, out_tlast on the bank's last
//   cell. data beats are taken back to back while the sequencer is idle; a pec beat starts
//   the cell sequencer, which takes each cell through four steps (two byte-store reads, one
//   count read-modify-write, one output register). the next bank's first byte is taken in
//   the cycle the last result is taken; a bank with no cells to check starts no sequencer
//   run. the first result is presented after the first cell's reads and count update.
// in_tready is low while the sequencer runs and rises again in the cycle the bank's
//   last result is taken; a stalled receiver holds the sequencer in its output step.
// cfg channel: always ready, writes take effect the next cycle; write only when idle.
// reset: config and crc return to their reset values; positions, comms counter, sticky
//   flags and the per-cell fault counts (valid bits) clear at once, no clearing pass.
module cell_voltage_frame_checker_top #(
  parameter int BANK_COUNT     = 3,
  parameter int BYTES_PER_BANK = 15
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // rx_byte
  input  logic                             in_tuser,   // frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // bank_index[1:0], cell_index[5:2], code_offset[18:6], in_range[19], pec_ok[20],
  // link_fault[21], bounds_fault[22], zero[23]
  output logic [cvfc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,  // last_of_bank
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cvfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cvfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cvfc_pkg::*;

  localparam int DATA_AW = $clog2(BYTES_PER_BANK);
  localparam int POS_W   = $clog2(BYTES_PER_BANK + 1);

  logic [CODE_W-1:0]  low_limit_r;
  logic [CODE_W-1:0]  high_limit_r;
  logic [COUNT_W-1:0] persist_r;
  logic [CELL_W-1:0]  cells_first_r;
  logic [CELL_W-1:0]  cells_other_r;
  logic [7:0]         pec_seed_r;

  logic [7:0]         crc_r;
  logic [POS_W-1:0]   byte_pos_r;
  logic [BANK_W-1:0]  bank_pos_r;
  logic [COUNT_W-1:0] comms_cnt_r;
  logic               comms_flag_r;

  logic               accept;
  logic [POS_W-1:0]   pos_eff;
  logic [BANK_W-1:0]  bank_eff;
  logic [7:0]         crc_eff;
  logic               is_data;
  logic               pec_ok;
  logic [COUNT_W-1:0] comms_cnt_nxt;
  logic               comms_flag_nxt;
  logic [CELL_W-1:0]  ncell_raw;
  logic [CELL_W-1:0]  ncell;
  logic               seq_start;
  logic               accept_ok;
  cvfc_cmd_t          cmd;
  cvfc_lim_t          lim;
  logic [DATA_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  logic               data_we;

  assign cfg_ready = 1'b1;
  assign in_tready = accept_ok;
  assign accept    = in_tvalid && in_tready;

  // frame start restarts position, bank and crc before the byte is taken
  assign pos_eff  = in_tuser ? '0 : byte_pos_r;
  assign bank_eff = in_tuser ? '0 : bank_pos_r;
  assign crc_eff  = in_tuser ? pec_seed_r : crc_r;
  assign is_data  = pos_eff < POS_W'(BYTES_PER_BANK);
  assign data_we  = accept && is_data;

  assign pec_ok         = (in_tdata == crc_eff);
  assign comms_cnt_nxt  = pec_ok ? '0 :
                          ((comms_cnt_r == COUNT_MAX) ? COUNT_MAX : comms_cnt_r + 4'd1);
  assign comms_flag_nxt = comms_flag_r | (!pec_ok && (comms_cnt_nxt >= persist_r));

  assign ncell_raw = (bank_eff == '0) ? cells_first_r : cells_other_r;
  assign ncell     = (ncell_raw > CELL_W'(CELLS_MAX)) ? CELL_W'(CELLS_MAX) : ncell_raw;
  assign seq_start = accept && !is_data && (ncell != '0);

  assign cmd.bank_index = bank_eff;
  assign cmd.ncell      = ncell;
  assign cmd.pec_ok     = pec_ok;
  assign cmd.link_fault = comms_flag_nxt;

  assign lim.low_limit  = low_limit_r;
  assign lim.high_limit = high_limit_r;
  assign lim.persist    = persist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r   <= LOW_LIMIT_RST;
      high_limit_r  <= HIGH_LIMIT_RST;
      persist_r     <= PERSIST_RST;
      cells_first_r <= CELLS_FIRST_RST;
      cells_other_r <= CELLS_OTHER_RST;
      pec_seed_r    <= PEC_SEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_LIMIT:   low_limit_r   <= cfg_data;
        REG_HIGH_LIMIT:  high_limit_r  <= cfg_data;
        REG_PERSIST:     persist_r     <= cfg_data[COUNT_W-1:0];
        REG_CELLS_FIRST: cells_first_r <= cfg_data[CELL_W-1:0];
        REG_CELLS_OTHER: cells_other_r <= cfg_data[CELL_W-1:0];
        REG_PEC_SEED:    pec_seed_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= PEC_SEED_RST;
      byte_pos_r   <= '0;
      bank_pos_r   <= '0;
      comms_cnt_r  <= '0;
      comms_flag_r <= 1'b0;
    end else if (accept) begin
      if (is_data) begin
        crc_r      <= crc8_byte(crc_eff, in_tdata);
        byte_pos_r <= pos_eff + POS_W'(1);
        bank_pos_r <= bank_eff;
      end else begin
        crc_r        <= pec_seed_r;
        byte_pos_r   <= '0;
        bank_pos_r   <= (bank_eff == BANK_W'(BANK_COUNT - 1)) ? '0 : bank_eff + BANK_W'(1);
        comms_cnt_r  <= comms_cnt_nxt;
        comms_flag_r <= comms_flag_nxt;
      end
    end
  end

  cvfc_ram #(
    .WIDTH (8),
    .DEPTH (BYTES_PER_BANK)
  ) u_byte_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (pos_eff[DATA_AW-1:0]),
    .wdata (in_tdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cvfc_cell_seq #(
    .BANK_COUNT     (BANK_COUNT),
    .BYTES_PER_BANK (BYTES_PER_BANK)
  ) u_cell_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (seq_start),
    .cmd        (cmd),
    .lim        (lim),
    .accept_ok  (accept_ok),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/tb_cell_voltage_frame_checker_top.sv -----
// testbench for the cell voltage frame checker: crc-checked byte banks in, scored cell results out
module tb_cell_voltage_frame_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cvfc_pkg::*;

  localparam int BANKS       = 3;
  localparam int BANK_BYTES  = 15;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 48;
  localparam int SETTLE      = 64;
  localparam int GAP_PCT     = 21;
  localparam int REPORT_MAX  = 10;
  localparam int DIR_STEPS   = 21;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {
    SEND_DATA,
    SEND_PEC_GOOD,
    SEND_PEC_BAD
  } send_kind_t;

  typedef struct packed {
    logic [7:0]          data;
    logic                start;
    send_kind_t          kind;
    logic                typed;
    logic [OFFSET_W-1:0] offset;
    logic                in_range;
    logic                pec_ok;
  } dir_step_t;

  // laid out as out_tdata, lowest field last
  typedef struct packed {
    logic                pad;
    logic                bounds_fault;
    logic                link_fault;
    logic                pec_ok;
    logic                in_range;
    logic [OFFSET_W-1:0] offset;
    logic [CELL_W-1:0]   cell_idx;
    logic [BANK_W-1:0]   bank;
  } cell_result_t;

  typedef struct packed {
    logic         last;
    cell_result_t word;
  } cell_beat_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic gap_free = 1'b0;
  int   errors = 0;
  int   results_checked = 0;
  int   beats_sent = 0;
  int   pec_misses = 0;
  int   settings_used = 1;

  // shadow of the block: configuration
  logic [CODE_W-1:0]  lim_lo, lim_hi;
  logic [COUNT_W-1:0] persist_cfg;
  logic [CELL_W-1:0]  cells_bank0, cells_later;
  logic [7:0]         seed_cfg;
  // shadow of the block: framing, crc and fault history
  logic [7:0]         crc_run;
  int                 byte_pos, bank_pos;
  logic [7:0]         bank_bytes [BANK_BYTES];
  logic [COUNT_W-1:0] comms_run;
  logic [COUNT_W-1:0] cell_runs [BANKS*CELLS_MAX];
  logic               comms_sticky, bounds_sticky;

  cell_beat_t expected_cells [$];

  // partial frame, restart, then a bank alternating codes 0 and 4095 closed by a bad pec
  dir_step_t directed_steps [DIR_STEPS] = '{
    '{8'h12, 1'b1, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h34, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hA5, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h5A, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h80, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h00, 1'b1, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hF0, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hF0, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hF0, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hF0, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hF0, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, SEND_DATA, 1'b0, 13'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, SEND_PEC_BAD, 1'b1, 13'h1E00, 1'b0, 1'b0}
  };

  cell_voltage_frame_checker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_cell_voltage_frame_checker_top: done, errors");
    $finish;
  end

  // crc-8 x^8+x^2+x+1, msb first, shift-then-xor form
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ d[i];
      r  = r << 1;
      if (fb) r = r ^ 8'h07;
    end
    return r;
  endfunction

  function automatic logic [7:0] stored_byte(input int idx);
    return (idx < BANK_BYTES) ? bank_bytes[idx] : 8'h00;
  endfunction

  // two 12-bit codes share three bytes, little end first
  function automatic logic [CODE_W-1:0] cell_code(input int c);
    logic [7:0] b0, b1, b2;
    int         base;
    base = (c / 2) * 3;
    b0 = stored_byte(base);
    b1 = stored_byte(base + 1);
    b2 = stored_byte(base + 2);
    if (c % 2 == 0) return {b1[3:0], b0};
    return {b2, b1[7:4]};
  endfunction

  function automatic void reset_shadow();
    lim_lo        = LOW_LIMIT_RST;
    lim_hi        = HIGH_LIMIT_RST;
    persist_cfg   = PERSIST_RST;
    cells_bank0   = CELLS_FIRST_RST;
    cells_later   = CELLS_OTHER_RST;
    seed_cfg      = PEC_SEED_RST;
    crc_run       = PEC_SEED_RST;
    byte_pos      = 0;
    bank_pos      = 0;
    comms_run     = '0;
    comms_sticky  = 1'b0;
    bounds_sticky = 1'b0;
    foreach (bank_bytes[i]) bank_bytes[i] = 8'h00;
    foreach (cell_runs[i]) cell_runs[i] = '0;
  endfunction

  // advance the shadow by one accepted byte, queue the cell results a pec byte gives
  function automatic void take_byte(input logic [7:0] rx, input logic start);
    logic [BANK_W-1:0] bank;
    logic [CODE_W-1:0] code;
    logic              pec_match, ok;
    int                ncell, slot;
    cell_beat_t        beat;
    if (start) begin
      byte_pos = 0;
      bank_pos = 0;
      crc_run  = seed_cfg;
    end
    if (byte_pos < BANK_BYTES) begin
      bank_bytes[byte_pos] = rx;
      crc_run = crc8_next(crc_run, rx);
      byte_pos++;
      return;
    end
    bank = (bank_pos >= BANKS) ? '0 : BANK_W'(bank_pos);
    pec_match = (rx == crc_run);
    if (pec_match) begin
      comms_run = '0;
    end else begin
      pec_misses++;
      if (comms_run != COUNT_MAX) comms_run++;
      if (comms_run >= persist_cfg) comms_sticky = 1'b1;
    end
    ncell = int'((bank == '0) ? cells_bank0 : cells_later);
    if (ncell > CELLS_MAX) ncell = CELLS_MAX;
    for (int c = 0; c < ncell; c++) begin
      code = cell_code(c);
      ok   = (code > lim_lo) && (code < lim_hi);
      slot = int'(bank) * CELLS_MAX + c;
      if (ok) begin
        cell_runs[slot] = '0;
      end else begin
        if (cell_runs[slot] != COUNT_MAX) cell_runs[slot]++;
        if (cell_runs[slot] >= persist_cfg) bounds_sticky = 1'b1;
      end
      beat                   = '0;
      beat.word.bank         = bank;
      beat.word.cell_idx     = CELL_W'(c);
      beat.word.offset       = {1'b0, code} - CODE_BIAS;
      beat.word.in_range     = ok;
      beat.word.pec_ok       = pec_match;
      beat.word.link_fault   = comms_sticky;
      beat.word.bounds_fault = bounds_sticky;
      beat.last              = (c + 1 == ncell);
      expected_cells.push_back(beat);
    end
    crc_run  = seed_cfg;
    byte_pos = 0;
    bank_pos = (int'(bank) + 1 >= BANKS) ? 0 : int'(bank) + 1;
  endfunction

  function automatic string show(input cell_beat_t b);
    return $sformatf({"bank %0d cell %0d offset %0d range %b pec %b comms %b",
                      " bounds %b last %b pad %b"},
                     b.word.bank, b.word.cell_idx, $signed(b.word.offset), b.word.in_range,
                     b.word.pec_ok, b.word.link_fault, b.word.bounds_fault, b.last,
                     b.word.pad);
  endfunction

  task automatic send_byte(input logic [7:0] rx, input logic start);
    while (!gap_free && $urandom_range(0, 99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    take_byte(rx, start);
    beats_sent++;
  endtask

  // mostly whole banks with random cells, some cut short, some loose bytes
  task automatic random_unit();
    int   roll, n;
    logic fs;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      fs = (byte_pos != 0) ||
           ((bank_pos == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0));
      for (int i = 0; i < BANK_BYTES; i++)
        send_byte(8'($urandom_range(0, 255)), (i == 0) ? fs : 1'b0);
      if ($urandom_range(0, 99) < 85) send_byte(crc_run, 1'b0);
      else send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (roll < 85) begin
      n = $urandom_range(1, BANK_BYTES - 1);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), (i == 0) && ($urandom_range(0, 1) == 1));
    end else begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOW_LIMIT:   lim_lo      = value;
      REG_HIGH_LIMIT:  lim_hi      = value;
      REG_PERSIST:     persist_cfg = value[COUNT_W-1:0];
      REG_CELLS_FIRST: cells_bank0 = value[CELL_W-1:0];
      REG_CELLS_OTHER: cells_later = value[CELL_W-1:0];
      REG_PEC_SEED:    seed_cfg    = value[7:0];
      default: ;
    endcase
  endtask

  // wait for every queued result to be taken, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input int phase);
    logic [CODE_W-1:0]  lo, hi;
    logic [COUNT_W-1:0] per;
    logic [CELL_W-1:0]  nf, no;
    logic [7:0]         sd, junk;
    junk = 8'($urandom_range(0, 255));
    case (phase)
      1: begin
        lo = 12'd0;    hi = 12'd4095; per = 4'd1;  nf = 4'd1;  no = 4'd10; sd = 8'h00;
      end
      2: begin
        lo = 12'd4095; hi = 12'd0;    per = 4'd15; nf = 4'd10; no = 4'd1;  sd = 8'hFF;
      end
      3: begin
        // zero persistence, empty first bank, oversized later banks
        lo = CODE_W'($urandom_range(0, 2047));
        hi = CODE_W'($urandom_range(2048, 4095));
        per = 4'd0; nf = 4'd0; no = 4'd15;
        sd = 8'($urandom_range(0, 255));
      end
      default: begin
        lo  = CODE_W'($urandom_range(0, 2047));
        hi  = CODE_W'($urandom_range(2048, 4095));
        per = COUNT_W'($urandom_range(1, 15));
        nf  = CELL_W'($urandom_range(1, 10));
        no  = CELL_W'($urandom_range(1, 10));
        sd  = 8'($urandom_range(0, 255));
      end
    endcase
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_PERSIST, {junk, per});
    write_reg(REG_CELLS_FIRST, {~junk, nf});
    write_reg(REG_CELLS_OTHER, {junk, no});
    write_reg(REG_PEC_SEED, {junk[3:0], sd});
    if (phase == 3) begin
      write_reg(REG_SPARE_6, CFG_DATA_W'($urandom_range(0, 4095)));
      write_reg(REG_SPARE_7, CFG_DATA_W'($urandom_range(0, 4095)));
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    cell_beat_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= gap_free || ($urandom_range(0, 99) >= GAP_PCT);
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata};
        if (expected_cells.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) $display("unexpected result beat: %s", show(got));
        end else begin
          want = expected_cells.pop_front();
          results_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("result %0d mismatch", results_checked);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic       [7:0] rx;
    int               mark, phase_start;
    cell_beat_t       typed_beat;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      case (directed_steps[i].kind)
        SEND_PEC_GOOD: rx = crc_run;
        SEND_PEC_BAD:  rx = ~crc_run;
        default:       rx = directed_steps[i].data;
      endcase
      mark = expected_cells.size();
      send_byte(rx, directed_steps[i].start);
      // first cell of the bank is known by hand
      if (directed_steps[i].typed && expected_cells.size() > mark) begin
        typed_beat                 = expected_cells[mark];
        typed_beat.word.offset     = directed_steps[i].offset;
        typed_beat.word.in_range   = directed_steps[i].in_range;
        typed_beat.word.pec_ok     = directed_steps[i].pec_ok;
        expected_cells[mark]       = typed_beat;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        configure(p);
        settings_used++;
      end
      gap_free <= (p == 2);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) random_unit();
    end
    drain();

    $display("covered %0d input beats under %0d register settings, %0d cell results checked",
             beats_sent, settings_used, results_checked);
    $display("%0d banks closed by a mismatching pec, %0d faults seen", pec_misses, errors);
    if (errors == 0) begin
      $display("tb_cell_voltage_frame_checker_top: done, clean");
    end else begin
      $display("tb_cell_voltage_frame_checker_top: done, errors");
    end
    $finish;
  end

endmodule
